>>> src/pal_pkg.sv
package pal_pkg;

    localparam int KEY_W  = 32;
    localparam int OP_W   = 2;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 10;
    localparam int STAT_W = 2;

    // cells per first-level group of the read-out OR tree
    localparam int GRP_SIZE = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        t_key             key_in;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_key              value_out;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
    } t_out_word;

    // per-cell control: broadcast operation plus this cell's place against the position
    typedef struct packed {
        logic ins;
        logic rem;
        logic rd;
        logic at;
        logic past;
    } t_cell_ctl;

endpackage

>>> src/pal_cell.sv
module pal_cell
    import pal_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_key      i_key,
    input  t_key      i_left,
    input  t_key      i_right,
    output t_key      o_entry,
    output t_key      o_tap
);

    t_key r_entry;
    t_key n_entry;

    // insert: take the key at the position, take the left neighbor above it
    // remove: take the right neighbor at and above the position
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && i_ctl.at) begin
            n_entry = i_key;
        end else if (i_ctl.ins && i_ctl.past) begin
            n_entry = i_left;
        end else if (i_ctl.rem && (i_ctl.at || i_ctl.past)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = (i_ctl.rd && i_ctl.at) ? r_entry : '0;

endmodule

>>> src/positional_array_list.sv
// Ordered list of signed 32-bit keys held in a row of CAPACITY cells, one entry per
// cell. Each request word (insert, remove or read at a position) is checked against
// the count in the cycle it is accepted. At that same edge the whole list moves.
// On an insert the cell at the position loads the key and every cell past it loads its
// left neighbor. On a remove every cell at or past the position loads its right
// neighbor. The addressed entry is picked out through a two-level OR tree: groups of
// 32 cells are reduced into registers at the accept edge, and the groups are reduced
// into the output register at the next edge. The result word is therefore valid from
// that next edge on. The input stalls while a request is in flight, so a new request
// is taken only once the last one has reached the result register. The result register
// holds a finished word while the receiver stalls, and the input stalls with it.
// Status gives full, out of range or empty refusals, and a refused request leaves the
// list untouched. Entries power up undefined; only entries below the count are ever
// read. Positions reach 511; length is the count carried in 10 bits.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    // control registers
    logic              r_pend;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [STAT_W-1:0] r_p_status;
    t_out_word         r_out;
    t_key              r_grp [NGRP];

    logic              w_accept;
    logic [CMP_W-1:0]  w_pos_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic              w_full;
    logic              w_ins_ok;
    logic              w_acc_ok;
    logic [STAT_W-1:0] w_status;
    logic [CNT_W-1:0]  n_count;
    t_key              w_value;

    t_key              w_entry [CAPACITY];
    t_key              w_tap   [NGRP*GRP_SIZE];
    t_cell_ctl         w_ctl   [CAPACITY];

    // Hold input while a word is in flight or the result register is stuck.
    assign o_stall  = r_pend | (r_out_valid & i_stall);
    assign w_accept = i_valid & ~o_stall;

    assign w_pos_x = CMP_W'(i_in.position);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    assign w_ins_ok = (i_in.op == OP_INSERT) && !w_full && !(w_pos_x > w_cnt_x);
    assign w_acc_ok = ((i_in.op == OP_REMOVE) || (i_in.op == OP_READ))
                      && (r_count != '0) && (w_pos_x < w_cnt_x);

    // Decide status and the new count from the count before the request.
    always_comb begin
        w_status = ST_OK;
        n_count  = r_count;
        case (i_in.op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE, OP_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (!(w_pos_x < w_cnt_x)) begin
                    w_status = ST_RANGE;
                end else if (i_in.op == OP_REMOVE) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Row of cells; each sees its neighbors and its place relative to the position.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_key w_left;
        t_key w_right;

        assign w_left  = (i == 0) ? w_entry[i] : w_entry[(i == 0) ? 0 : i - 1];
        assign w_right = (i == CAPACITY - 1) ? w_entry[i]
                                             : w_entry[(i == CAPACITY - 1) ? i : i + 1];

        assign w_ctl[i] = '{
            ins:  w_accept & w_ins_ok,
            rem:  w_accept & w_acc_ok & (i_in.op == OP_REMOVE),
            rd:   w_accept & w_acc_ok,
            at:   (w_pos_x == CMP_W'(i)),
            past: (w_pos_x <  CMP_W'(i))
        };

        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_key   (i_in.key_in),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[i]),
            .o_tap   (w_tap[i])
        );
    end

    // Pad the last group with zero taps.
    for (genvar i = CAPACITY; i < NGRP*GRP_SIZE; i++) begin : g_pad
        assign w_tap[i] = '0;
    end

    // First tree level: reduce each group of taps at the accept edge.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            t_key v_acc;
            v_acc = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                v_acc = v_acc | w_tap[g*GRP_SIZE + k];
            end
            r_grp[g] <= v_acc;
        end
    end

    // Second tree level: combine the groups into the result word.
    always_comb begin
        w_value = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_value = w_value | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_pend <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
            // Set valid at the edge after the accept edge, drop it once taken.
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: status of the word in flight and the finished result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_status <= w_status;
        end
        if (r_pend) begin
            r_out.status    <= r_p_status;
            r_out.value_out <= w_value;
            r_out.length    <= LEN_W'(r_count);
            r_out.is_empty  <= (r_count == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_pend_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("word in flight did not reach the result register");

    a_pend_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("result register busy while a word is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the list");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |-> (r_out.value_out == '0))
        else $error("refused request returned a nonzero value");

endmodule
